// ===== design/vmsg_pkg.sv =====
`default_nettype none

package vmsg_pkg;

  // Default field widths
  localparam int GRAD_WIDTH_DEF    = 24;
  localparam int MODULUS_WIDTH_DEF = 24;

  // Result field width; larger roots saturate
  localparam int OUT_WIDTH = 54;

  // Operand slice width for the wide products
  localparam int MUL_CHUNK = 32;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAME  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEAR = 1'd1;

endpackage

`default_nettype wire

// ===== design/vmsg_strain.sv =====
`default_nettype none

// Deviator terms, their squares and their sum: three stages.
// P = sum over i,j of (3*e_ij - d_ij*tr e)^2 with e = g + g^T.
module vmsg_strain #(
  parameter int GW = vmsg_pkg::GRAD_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [GW-1:0] g_xx,
  input  logic signed [GW-1:0] g_xy,
  input  logic signed [GW-1:0] g_xz,
  input  logic signed [GW-1:0] g_yx,
  input  logic signed [GW-1:0] g_yy,
  input  logic signed [GW-1:0] g_yz,
  input  logic signed [GW-1:0] g_zx,
  input  logic signed [GW-1:0] g_zy,
  input  logic signed [GW-1:0] g_zz,
  output logic                 p_valid,
  input  logic                 p_stall,
  output logic [2*GW+9:0]      p_data
);

  localparam int TW   = GW + 4;      // signed term
  localparam int MAGW = GW + 3;      // term magnitude
  localparam int SQW  = 2 * MAGW;    // square
  localparam int PW   = 2 * GW + 10; // sum of squares

  logic [2:0] v_r;
  logic [3:0] go;

  logic signed [TW-1:0] e_xx, e_yy, e_zz, s_xy, s_xz, s_yz;
  logic signed [TW-1:0] t [6];
  logic [MAGW-1:0] mag_nxt [6];
  logic [MAGW-1:0] mag_r [6];
  logic [SQW-1:0]  sq_r [6];
  logic [PW-1:0]   p_nxt, p_r;

  // Stall chain: a stage loads when empty or when the next one loads
  assign go[3] = !p_stall;
  assign go[2] = !v_r[2] || go[3];
  assign go[1] = !v_r[1] || go[2];
  assign go[0] = !v_r[0] || go[1];
  assign in_stall = !go[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (go[0]) v_r[0] <= in_valid;
      if (go[1]) v_r[1] <= v_r[0];
      if (go[2]) v_r[2] <= v_r[1];
    end
  end

  // Stage 1: symmetric strain, deviator terms, magnitudes
  always_comb begin
    e_xx = TW'(g_xx) + TW'(g_xx);
    e_yy = TW'(g_yy) + TW'(g_yy);
    e_zz = TW'(g_zz) + TW'(g_zz);
    s_xy = TW'(g_xy) + TW'(g_yx);
    s_xz = TW'(g_xz) + TW'(g_zx);
    s_yz = TW'(g_yz) + TW'(g_zy);
    t[0] = (e_xx <<< 1) - e_yy - e_zz;
    t[1] = (e_yy <<< 1) - e_xx - e_zz;
    t[2] = (e_zz <<< 1) - e_xx - e_yy;
    t[3] = (s_xy <<< 1) + s_xy;
    t[4] = (s_xz <<< 1) + s_xz;
    t[5] = (s_yz <<< 1) + s_yz;
    for (int i = 0; i < 6; i++) begin
      mag_nxt[i] = t[i][TW-1] ? MAGW'(-t[i]) : MAGW'(t[i]);
    end
  end

  // Stage 3 sum; off-diagonal terms count twice
  always_comb begin
    p_nxt = PW'(sq_r[0]) + PW'(sq_r[1]) + PW'(sq_r[2])
          + ((PW'(sq_r[3]) + PW'(sq_r[4]) + PW'(sq_r[5])) << 1);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      if (go[0]) mag_r[i] <= mag_nxt[i];
      if (go[1]) sq_r[i]  <= SQW'(mag_r[i]) * SQW'(mag_r[i]);
    end
    if (go[2]) p_r <= p_nxt;
  end

  assign p_valid = v_r[2];
  assign p_data  = p_r;

endmodule

`default_nettype wire

// ===== design/vmsg_scale.sv =====
`default_nettype none

// Q = P * mu * mu, as two sliced products, four stages.
module vmsg_scale #(
  parameter int GW = vmsg_pkg::GRAD_WIDTH_DEF,
  parameter int MW = vmsg_pkg::MODULUS_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [MW-1:0]            mu,
  input  logic                     p_valid,
  output logic                     p_stall,
  input  logic [2*GW+9:0]          p_data,
  output logic                     q_valid,
  input  logic                     q_stall,
  output logic [2*GW+9+2*MW:0]     q_data
);

  localparam int PW  = 2 * GW + 10;
  localparam int AW  = PW + MW;
  localparam int QW  = AW + MW;
  localparam int CH  = vmsg_pkg::MUL_CHUNK;
  localparam int NC1 = (PW + CH - 1) / CH;
  localparam int NC2 = (AW + CH - 1) / CH;
  localparam int P1W = NC1 * CH;
  localparam int P2W = NC2 * CH;
  localparam int PPW = CH + MW;

  logic [3:0] v_r;
  logic [4:0] go;

  logic [P1W-1:0] p_pad;
  logic [P2W-1:0] a_pad;
  logic [PPW-1:0] part1_r [NC1];
  logic [PPW-1:0] part2_r [NC2];
  logic [AW-1:0]  a_nxt, a_r;
  logic [QW-1:0]  q_nxt, q_r;

  assign go[4] = !q_stall;
  assign go[3] = !v_r[3] || go[4];
  assign go[2] = !v_r[2] || go[3];
  assign go[1] = !v_r[1] || go[2];
  assign go[0] = !v_r[0] || go[1];
  assign p_stall = !go[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (go[0]) v_r[0] <= p_valid;
      if (go[1]) v_r[1] <= v_r[0];
      if (go[2]) v_r[2] <= v_r[1];
      if (go[3]) v_r[3] <= v_r[2];
    end
  end

  assign p_pad = P1W'(p_data);
  assign a_pad = P2W'(a_r);

  // Recombine the sliced partial products
  always_comb begin
    a_nxt = '0;
    for (int i = 0; i < NC1; i++) begin
      a_nxt = a_nxt + (AW'(part1_r[i]) << (i * CH));
    end
    q_nxt = '0;
    for (int i = 0; i < NC2; i++) begin
      q_nxt = q_nxt + (QW'(part2_r[i]) << (i * CH));
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NC1; i++) begin
      if (go[0]) part1_r[i] <= PPW'(p_pad[i*CH +: CH]) * PPW'(mu);
    end
    if (go[1]) a_r <= a_nxt;
    for (int i = 0; i < NC2; i++) begin
      if (go[2]) part2_r[i] <= PPW'(a_pad[i*CH +: CH]) * PPW'(mu);
    end
    if (go[3]) q_r <= q_nxt;
  end

  assign q_valid = v_r[3];
  assign q_data  = q_r;

endmodule

`default_nettype wire

// ===== design/vmsg_sqrt.sv =====
`default_nettype none

// Largest r with 6*r*r <= Q, one root bit per stage, MSB first.
// Equals floor(sqrt(floor(Q/6))). u carries 12*r, so the trial value
// (12*r + 6*2^b) * 2^b is a plain OR and shift.
module vmsg_sqrt #(
  parameter int QW = 106
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_stall,
  input  logic [QW-1:0]     q_data,
  output logic              root_valid,
  input  logic              root_stall,
  output logic [QW/2-1:0]   root_data
);

  localparam int RW = QW / 2;
  localparam int NS = RW;
  localparam int XW = QW + 4;
  localparam int UW = RW + 4;

  logic [NS-1:0] v_r;
  logic [NS:0]   go;
  logic [QW-1:0] rem_r  [NS];
  logic [UW-1:0] u_r    [NS];
  logic [RW-1:0] root_r [NS];

  assign go[NS]  = !root_stall;
  assign q_stall = !go[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int B = RW - 1 - k;

    logic [QW-1:0] rem_in;
    logic [UW-1:0] u_in;
    logic [RW-1:0] root_in;
    logic          v_in;
    logic [XW-1:0] trial;
    logic          fits;

    if (k == 0) begin : g_first
      assign rem_in  = q_data;
      assign u_in    = '0;
      assign root_in = '0;
      assign v_in    = q_valid;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign u_in    = u_r[k-1];
      assign root_in = root_r[k-1];
      assign v_in    = v_r[k-1];
    end

    assign go[k] = !v_r[k] || go[k+1];

    // Try setting bit B of the root
    assign trial = (XW'(u_in) | (XW'(6) << B)) << B;
    assign fits  = trial <= XW'(rem_in);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (go[k]) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (go[k]) begin
        rem_r[k]  <= fits ? QW'(XW'(rem_in) - trial) : rem_in;
        u_r[k]    <= fits ? u_in + (UW'(12) << B) : u_in;
        root_r[k] <= root_in | (RW'(fits) << B);
      end
    end
  end

  assign root_valid = v_r[NS-1];
  assign root_data  = root_r[NS-1];

endmodule

`default_nettype wire

// ===== design/von_mises_stress_from_gradient_unit.sv =====
`default_nettype none

// Von Mises stress of an isotropic linear-elastic point from its 3x3
// displacement gradient, exact on integers: the result is
// floor(sqrt(floor(Q/6))) with Q = mu^2 * sum (3*e_ij - d_ij*tr e)^2,
// e = g + g^T, at the fraction scale of the gradient (the scale itself
// never enters the logic). lambda cancels in the deviator, so a write to
// lame_first is taken but has no effect. One item enters per clock while
// in_stall is low; the square-root pipeline resolves one root bit per
// stage. Results above 2^54-1 saturate. Configuration is to be written
// by the user only while no item is in flight; the block itself does
// not enforce this.
module von_mises_stress_from_gradient_unit #(
  parameter int GRAD_WIDTH    = vmsg_pkg::GRAD_WIDTH_DEF,
  parameter int MODULUS_WIDTH = vmsg_pkg::MODULUS_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wen,
  input  logic [vmsg_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [MODULUS_WIDTH-1:0]           cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [GRAD_WIDTH-1:0]       in_grad_xx,
  input  logic signed [GRAD_WIDTH-1:0]       in_grad_xy,
  input  logic signed [GRAD_WIDTH-1:0]       in_grad_xz,
  input  logic signed [GRAD_WIDTH-1:0]       in_grad_yx,
  input  logic signed [GRAD_WIDTH-1:0]       in_grad_yy,
  input  logic signed [GRAD_WIDTH-1:0]       in_grad_yz,
  input  logic signed [GRAD_WIDTH-1:0]       in_grad_zx,
  input  logic signed [GRAD_WIDTH-1:0]       in_grad_zy,
  input  logic signed [GRAD_WIDTH-1:0]       in_grad_zz,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [vmsg_pkg::OUT_WIDTH-1:0]     out_von_mises_stress
);

  localparam int PW = 2 * GRAD_WIDTH + 10;
  localparam int QW = PW + 2 * MODULUS_WIDTH;
  localparam int RW = QW / 2;
  localparam int OW = vmsg_pkg::OUT_WIDTH;

  logic [MODULUS_WIDTH-1:0] shear_r;
  logic                     p_valid, p_stall, q_valid, q_stall;
  logic                     root_valid, root_stall;
  logic [PW-1:0]            p_data;
  logic [QW-1:0]            q_data;
  logic [RW-1:0]            root_data;
  logic [OW-1:0]            res_nxt;
  logic                     out_valid_r;
  logic [OW-1:0]            out_data_r;
  logic                     go_out;

  // Configuration register: only the shear modulus is stored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shear_r <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        vmsg_pkg::CFG_LAME:  ;  // cancels in the deviator
        vmsg_pkg::CFG_SHEAR: shear_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  vmsg_strain #(.GW(GRAD_WIDTH)) u_strain (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .g_xx     (in_grad_xx),
    .g_xy     (in_grad_xy),
    .g_xz     (in_grad_xz),
    .g_yx     (in_grad_yx),
    .g_yy     (in_grad_yy),
    .g_yz     (in_grad_yz),
    .g_zx     (in_grad_zx),
    .g_zy     (in_grad_zy),
    .g_zz     (in_grad_zz),
    .p_valid  (p_valid),
    .p_stall  (p_stall),
    .p_data   (p_data)
  );

  vmsg_scale #(.GW(GRAD_WIDTH), .MW(MODULUS_WIDTH)) u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .mu      (shear_r),
    .p_valid (p_valid),
    .p_stall (p_stall),
    .p_data  (p_data),
    .q_valid (q_valid),
    .q_stall (q_stall),
    .q_data  (q_data)
  );

  vmsg_sqrt #(.QW(QW)) u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_stall    (q_stall),
    .q_data     (q_data),
    .root_valid (root_valid),
    .root_stall (root_stall),
    .root_data  (root_data)
  );

  // Saturate to the result width
  if (RW > OW) begin : g_sat
    assign res_nxt = (|root_data[RW-1:OW]) ? '1 : root_data[OW-1:0];
  end else begin : g_fit
    assign res_nxt = OW'(root_data);
  end

  // Output register
  assign go_out     = !out_valid_r || !out_stall;
  assign root_stall = !go_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (go_out) begin
      out_valid_r <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go_out) out_data_r <= res_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_von_mises_stress = out_data_r;

  // Input back-pressure only ever comes from a held result
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled while output register empty");

  // A result leaves only when taken
  a_result_taken: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(out_valid_r) && $past(rst_n)) |-> $past(!out_stall))
    else $error("result dropped while stalled");

endmodule

`default_nettype wire

// ===== tb/von_mises_stress_from_gradient_unit_tb.sv =====
`default_nettype none

module von_mises_stress_from_gradient_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GW = vmsg_pkg::GRAD_WIDTH_DEF;
  localparam int MW = vmsg_pkg::MODULUS_WIDTH_DEF;
  localparam int LATENCY = 61;

  typedef logic signed [GW-1:0] grad_t;
  typedef logic [vmsg_pkg::OUT_WIDTH-1:0] stress_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wen = 1'b0;
  logic [vmsg_pkg::CFG_IDX_W-1:0] cfg_idx = vmsg_pkg::CFG_LAME;
  logic [MW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  grad_t g_xx = '0, g_xy = '0, g_xz = '0, g_yx = '0, g_yy = '0;
  grad_t g_yz = '0, g_zx = '0, g_zy = '0, g_zz = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  stress_t out_stress;

  // predictor copy of the registers
  logic [MW-1:0] lame_reg = '0;
  logic [MW-1:0] shear_reg = '0;

  stress_t expected_stress[$];
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  bit idle_enable = 1'b1;
  int unsigned hold_cycles = 0;
  // long hold requests: raised by the tests, taken up by the stall process
  int unsigned hold_req_count = 0;
  int unsigned hold_req_seen = 0;

  always #6 clk = ~clk;

  von_mises_stress_from_gradient_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wen(cfg_wen), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_grad_xx(g_xx), .in_grad_xy(g_xy), .in_grad_xz(g_xz),
    .in_grad_yx(g_yx), .in_grad_yy(g_yy), .in_grad_yz(g_yz),
    .in_grad_zx(g_zx), .in_grad_zy(g_zy), .in_grad_zz(g_zz),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_von_mises_stress(out_stress)
  );

  // exact integer square root, bit by bit
  function automatic logic [127:0] isqrt256(input logic [255:0] n);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 127; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if ({128'd0, c} * {128'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  // von Mises stress from a gradient: lambda cancels in the deviator
  function automatic stress_t predict_stress(input grad_t g[9]);
    logic signed [63:0] e[3][3];
    logic signed [63:0] tr, t;
    logic [255:0] q, mag;
    logic [127:0] root;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        e[i][j] = 64'(g[i*3+j]) + 64'(g[j*3+i]);
    tr = e[0][0] + e[1][1] + e[2][2];
    q = '0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        t = 3 * e[i][j] - ((i == j) ? tr : 64'sd0);
        mag = (t < 0) ? 256'(-t) : 256'(t);
        q += mag * mag;
      end
    q = q * 256'(shear_reg) * 256'(shear_reg);
    q = q / 6;
    root = isqrt256(q);
    if (root > 128'((64'd1 << vmsg_pkg::OUT_WIDTH) - 1)) return '1;
    return root[vmsg_pkg::OUT_WIDTH-1:0];
  endfunction

  task automatic report_mismatch(input string what, input stress_t got, input stress_t exp);
    mismatches++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_stress.size() == 0) report_mismatch("unexpected result", out_stress, '0);
      else begin
        stress_t e;
        e = expected_stress.pop_front();
        if (out_stress !== e) report_mismatch("von_mises_stress", out_stress, e);
      end
    end
  end

  // receiver stall: random bursts, or a long forced hold
  always @(posedge clk) begin
    if (hold_req_seen != hold_req_count) begin
      hold_req_seen <= hold_req_count;
      hold_cycles <= 149;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      hold_cycles <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic write_reg(input logic [vmsg_pkg::CFG_IDX_W-1:0] idx, input logic [MW-1:0] val);
    cfg_wen <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    if (idx == vmsg_pkg::CFG_LAME) lame_reg = val;
    else if (idx == vmsg_pkg::CFG_SHEAR) shear_reg = val;
  endtask

  // send one item; valid stays high across back-to-back items
  task automatic send_item(input grad_t g[9]);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    g_xx <= g[0]; g_xy <= g[1]; g_xz <= g[2];
    g_yx <= g[3]; g_yy <= g[4]; g_yz <= g[5];
    g_zx <= g[6]; g_zy <= g[7]; g_zz <= g[8];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_stress.push_back(predict_stress(g));
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_stress.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic grad_t rand_grad(input int mode);
    case (mode)
      0: return grad_t'($urandom);
      1: return grad_t'($urandom_range(0, 2000)) - grad_t'(1000);
      2: return $urandom_range(0, 1) ? {1'b0, {(GW-1){1'b1}}} : {1'b1, {(GW-1){1'b0}}};
      default: return grad_t'($urandom_range(0, 1) << $urandom_range(0, GW-1));
    endcase
  endfunction

  task automatic test_directed();
    grad_t g[9];
    write_reg(vmsg_pkg::CFG_LAME, '1);
    write_reg(vmsg_pkg::CFG_SHEAR, '1);
    foreach (g[i]) g[i] = '0;
    send_item(g);
    foreach (g[i]) g[i] = {1'b0, {(GW-1){1'b1}}};
    send_item(g);
    foreach (g[i]) g[i] = {1'b1, {(GW-1){1'b0}}};
    send_item(g);
    foreach (g[i]) g[i] = '1;
    send_item(g);
    // alternating extremes: largest shear differences
    foreach (g[i]) g[i] = (i % 2) ? {1'b1, {(GW-1){1'b0}}} : {1'b0, {(GW-1){1'b1}}};
    send_item(g);
    // pure hydrostatic strain gives zero deviator
    foreach (g[i]) g[i] = '0;
    g[0] = 24'sd1048576; g[4] = 24'sd1048576; g[8] = 24'sd1048576;
    send_item(g);
    // one-hot entries, each in turn
    for (int k = 0; k < 9; k++) begin
      foreach (g[i]) g[i] = '0;
      g[k] = (k % 2) ? {1'b1, {(GW-1){1'b0}}} : 24'sd1048576;
      send_item(g);
    end
    // antisymmetric gradient: pure rotation, no stress
    foreach (g[i]) g[i] = '0;
    g[1] = 24'sd5000; g[3] = -24'sd5000;
    send_item(g);
    drain();
  endtask

  task automatic test_config_sweep();
    grad_t g[9];
    logic [MW-1:0] shear_vals[4];
    shear_vals = '{'0, 24'd1, 24'd80000, '1};
    foreach (shear_vals[s]) begin
      write_reg(vmsg_pkg::CFG_SHEAR, shear_vals[s]);
      write_reg(vmsg_pkg::CFG_LAME, MW'($urandom));
      for (int n = 0; n < 10; n++) begin
        foreach (g[i]) g[i] = rand_grad($urandom_range(0, 3));
        send_item(g);
      end
      drain();
    end
  endtask

  task automatic test_backpressure();
    grad_t g[9];
    write_reg(vmsg_pkg::CFG_SHEAR, 24'd123457);
    @(posedge clk);
    hold_req_count++;
    for (int n = 0; n < 80; n++) begin
      foreach (g[i]) g[i] = rand_grad(0);
      send_item(g);
    end
    drain();
  endtask

  task automatic test_random();
    grad_t g[9];
    for (int n = 0; n < 330; n++) begin
      if (n % 60 == 0) begin
        drain();
        write_reg(vmsg_pkg::CFG_SHEAR, MW'($urandom));
        write_reg(vmsg_pkg::CFG_LAME, MW'($urandom));
      end
      if (n == 270) idle_enable = 1'b0;
      foreach (g[i]) g[i] = rand_grad($urandom_range(0, 3));
      send_item(g);
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_random();
    $display("Sent %0d gradients, checked %0d stresses across shear settings",
             items_sent, results_seen);
    $display("including zero, full-scale and back-pressure phases");
    if (mismatches == 0 && expected_stress.size() == 0)
      $display("von_mises_stress_from_gradient_unit_tb OK");
    else
      $display("von_mises_stress_from_gradient_unit_tb NOT OK");
    $finish;
  end

  // run limit
  initial begin
    #2ms;
    $display("timeout");
    $display("von_mises_stress_from_gradient_unit_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
